FILE: hdl/zowl_pkg.sv
package zowl_pkg;

   localparam int LIST_DEPTH_DEF = 16;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_PUSH   = 2'd1,
      MODE_DETACH = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_MISSING = 3'd2,
      ST_DUP     = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  win_id;
      logic [15:0] z_value;
   } entry_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  win_id;
      logic [15:0] z_value;
      logic [3:0]  rank;
   } op_type;

   // Update strobes from the top level to every cell.
   typedef struct packed {
      logic ins;
      logic del;
   } ctl_type;

endpackage

FILE: hdl/zowl_cell.sv
module zowl_cell
   import zowl_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int INDEX      = 0
) (
   input  logic                              clock,
   input  logic [$clog2(LIST_DEPTH+1)-1:0]   count,
   input  op_type                            op,
   input  ctl_type                           ctl,
   input  entry_type                         above,
   input  entry_type                         below,
   input  logic                              match_seen_in,
   input  logic                              place_seen_in,
   output logic                              match_seen_out,
   output logic                              place_seen_out,
   output logic                              match_first,
   output logic                              place_first,
   output entry_type                         cur,
   output entry_type                         nxt
);

   localparam int CW = $clog2(LIST_DEPTH+1);
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   entry_type ent_ff;
   entry_type ent_in;
   logic      occ;
   logic      id_eq;
   logic      place_cond;

   assign occ   = IDX < count;
   assign id_eq = occ && (ent_ff.win_id == op.win_id);

   always_comb begin
      unique case (op.mode)
         MODE_INSERT: place_cond = !occ || (ent_ff.z_value < op.z_value);
         MODE_PUSH:   place_cond = (INDEX == 0);
         MODE_DETACH: place_cond = id_eq;
         MODE_READ:   place_cond = (int'(op.rank) == INDEX);
         default:     place_cond = 1'b0;
      endcase
   end

   assign match_seen_out = match_seen_in | id_eq;
   assign match_first    = id_eq & !match_seen_in;
   assign place_seen_out = place_seen_in | place_cond;
   assign place_first    = place_cond & !place_seen_in;

   // On an insert every cell below the gap takes its upper neighbour's word;
   // on a detach every cell from the removed one down takes the lower word.
   always_comb begin
      ent_in = ent_ff;
      if (ctl.ins) begin
         if (place_seen_in) begin
            ent_in = above;
         end else if (place_cond) begin
            ent_in.win_id  = op.win_id;
            ent_in.z_value = op.z_value;
         end
      end else if (ctl.del) begin
         if (place_seen_out) begin
            ent_in = below;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ins || ctl.del) begin
         ent_ff <= ent_in;
      end
   end

   assign cur = ent_ff;
   assign nxt = ent_in;

endmodule

FILE: hdl/z_ordered_window_list.sv
// Channel   Direction  Handshake               Word
// req       in         req_valid / req_stall   mode, win_id, z_value, rank
// rsp       out        rsp_valid / rsp_stall   status, position, entry_count,
//                                              top_id, read_id, read_z
//
// A word is accepted into a request register; the cell chain evaluates it and
// the result is registered and offered from the response registers. A new word
// can be accepted every cycle while the result is not stalled.
// The priority chains through the LIST_DEPTH cells set the evaluation path.
// Synchronous reset empties the list and clears both handshake registers.
// While the result is stalled one further word is held in the request register.
module z_ordered_window_list
   import zowl_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_win_id,
   input  logic [15:0] req_z_value,
   input  logic [3:0]  req_rank,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_position,
   output logic [4:0]  rsp_entry_count,
   output logic [7:0]  rsp_top_id,
   output logic [7:0]  rsp_read_id,
   output logic [15:0] rsp_read_z
);

   localparam int CW = $clog2(LIST_DEPTH+1);
   localparam int IW = $clog2(LIST_DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

   logic          req_full_ff;
   op_type        op_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   status_type    status_ff;
   status_type    status_in;
   logic [3:0]    pos_ff;
   logic [3:0]    pos_in;
   logic [4:0]    ecount_ff;
   logic [7:0]    top_id_ff;
   logic [7:0]    top_id_in;
   logic [7:0]    read_id_ff;
   logic [7:0]    read_id_in;
   logic [15:0]   read_z_ff;
   logic [15:0]   read_z_in;
   logic          eval;
   ctl_type       ctl;

   logic [LIST_DEPTH:0]   match_seen;
   logic [LIST_DEPTH:0]   place_seen;
   logic [LIST_DEPTH-1:0] match_first;
   logic [LIST_DEPTH-1:0] place_first;
   entry_type             cur   [LIST_DEPTH];
   entry_type             nxt   [LIST_DEPTH];
   entry_type             above [LIST_DEPTH];
   entry_type             below [LIST_DEPTH];
   logic [IW-1:0]         match_pos;
   logic [IW-1:0]         place_pos;
   entry_type             read_ent;

   assign eval      = req_full_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_full_ff && !eval;

   assign match_seen[0] = 1'b0;
   assign place_seen[0] = 1'b0;

   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign above[g] = cur[g];
      end else begin : g_body
         assign above[g] = cur[g-1];
      end
      if (g == LIST_DEPTH-1) begin : g_tail
         assign below[g] = cur[g];
      end else begin : g_inner
         assign below[g] = cur[g+1];
      end

      zowl_cell #(
         .LIST_DEPTH(LIST_DEPTH),
         .INDEX     (g)
      ) u_cell (
         .clock         (clock),
         .count         (count_ff),
         .op            (op_ff),
         .ctl           (ctl),
         .above         (above[g]),
         .below         (below[g]),
         .match_seen_in (match_seen[g]),
         .place_seen_in (place_seen[g]),
         .match_seen_out(match_seen[g+1]),
         .place_seen_out(place_seen[g+1]),
         .match_first   (match_first[g]),
         .place_first   (place_first[g]),
         .cur           (cur[g]),
         .nxt           (nxt[g])
      );
   end

   // At most one cell flags itself first in each chain, so the ranks and the
   // read word are plain OR reductions.
   always_comb begin
      match_pos = '0;
      place_pos = '0;
      read_ent  = '0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         if (match_first[i]) begin
            match_pos = match_pos | IW'(i);
         end
         if (place_first[i]) begin
            place_pos = place_pos | IW'(i);
            read_ent  = read_ent | cur[i];
         end
      end
   end

   always_comb begin
      status_in  = ST_OK;
      pos_in     = '0;
      count_in   = count_ff;
      ctl        = '0;
      read_id_in = '0;
      read_z_in  = '0;
      unique case (op_ff.mode)
         MODE_INSERT, MODE_PUSH: begin
            priority if (match_seen[LIST_DEPTH]) begin
               status_in = ST_DUP;
               pos_in    = 4'(match_pos);
            end else if (count_ff == FULL_COUNT) begin
               status_in = ST_FULL;
            end else begin
               ctl.ins  = eval;
               pos_in   = 4'(place_pos);
               count_in = count_ff + 1'b1;
            end
         end
         MODE_DETACH: begin
            if (match_seen[LIST_DEPTH]) begin
               ctl.del  = eval;
               pos_in   = 4'(match_pos);
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_MISSING;
            end
         end
         MODE_READ: begin
            pos_in = op_ff.rank;
            if (int'(op_ff.rank) < int'(count_ff)) begin
               read_id_in = read_ent.win_id;
               read_z_in  = read_ent.z_value;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: status_in = ST_OK;
      endcase
      top_id_in = (count_in != '0) ? nxt[0].win_id : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            req_full_ff <= 1'b1;
         end else if (eval) begin
            req_full_ff <= 1'b0;
         end
         if (eval) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff.mode    <= mode_type'(req_mode);
         op_ff.win_id  <= req_win_id;
         op_ff.z_value <= req_z_value;
         op_ff.rank    <= req_rank;
      end
      if (eval) begin
         status_ff  <= status_in;
         pos_ff     <= pos_in;
         ecount_ff  <= 5'(count_in);
         top_id_ff  <= top_id_in;
         read_id_ff <= read_id_in;
         read_z_ff  <= read_z_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_entry_count = ecount_ff;
   assign rsp_top_id      = top_id_ff;
   assign rsp_read_id     = read_id_ff;
   assign rsp_read_z      = read_z_ff;

endmodule

FILE: hdl/zowl_checker.sv
module zowl_checker
   import zowl_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [4:0]  rsp_entry_count,
   input logic [7:0]  rsp_top_id,
   input logic [7:0]  rsp_read_id,
   input logic [15:0] rsp_read_z
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == 5'(LIST_DEPTH))
      else $error("full status with a list that is not full");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_count == 5'd0) && (LIST_DEPTH < 32) |-> rsp_top_id == 8'd0)
      else $error("top id given for an empty list");

   // Only a successful read returns an entry.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_read_id == 8'd0) && (rsp_read_z == 16'd0))
      else $error("read data on a failed operation");

endmodule

bind z_ordered_window_list zowl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_zowl_checker (.*);

FILE: test/tb_z_ordered_window_list.sv
module tb_z_ordered_window_list;
   import zowl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      status_type  status;
      logic [3:0]  position;
      logic [4:0]  entry_count;
      logic [7:0]  top_id;
      logic [7:0]  read_id;
      logic [15:0] read_z;
   } window_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_READ;
   logic [7:0]  req_win_id = 8'h00;
   logic [15:0] req_z_value = 16'h0000;
   logic [3:0]  req_rank = 4'h0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_position;
   logic [4:0]  rsp_entry_count;
   logic [7:0]  rsp_top_id;
   logic [7:0]  rsp_read_id;
   logic [15:0] rsp_read_z;

   // Predicted contents of the window list, rank 0 first.
   logic [7:0]  list_ids  [0:LIST_DEPTH_DEF-1];
   logic [15:0] list_keys [0:LIST_DEPTH_DEF-1];
   int          list_len = 0;

   window_reply_type replies_due[$];
   int error_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_cycles = 0;
   int cycles_run = 0;

   z_ordered_window_list #(.LIST_DEPTH(LIST_DEPTH_DEF)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_win_id      (req_win_id),
      .req_z_value     (req_z_value),
      .req_rank        (req_rank),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_top_id      (rsp_top_id),
      .rsp_read_id     (rsp_read_id),
      .rsp_read_z      (rsp_read_z)
   );

   always #1 clock = ~clock;

   function automatic window_reply_type apply_window_op(input mode_type mode,
                                                        input logic [7:0] id,
                                                        input logic [15:0] z,
                                                        input logic [3:0] rank);
      window_reply_type r;
      int hit;
      int pos;
      r.status = ST_OK;
      r.read_id = 8'h00;
      r.read_z = 16'h0000;
      hit = list_len;
      pos = 0;
      for (int i = 0; i < list_len; i++) begin
         if (list_ids[i] == id && hit == list_len) hit = i;
      end
      unique case (mode)
         MODE_INSERT, MODE_PUSH: begin
            // The duplicate check takes priority over the full check.
            if (hit < list_len) begin
               r.status = ST_DUP;
               pos = hit;
            end else if (list_len >= LIST_DEPTH_DEF) begin
               r.status = ST_FULL;
            end else begin
               if (mode == MODE_INSERT) begin
                  while (pos < list_len && list_keys[pos] >= z) pos++;
               end
               for (int i = list_len; i > pos; i--) begin
                  list_ids[i] = list_ids[i-1];
                  list_keys[i] = list_keys[i-1];
               end
               list_ids[pos] = id;
               list_keys[pos] = z;
               list_len++;
            end
         end
         MODE_DETACH: begin
            if (hit < list_len) begin
               pos = hit;
               for (int i = hit; i + 1 < list_len; i++) begin
                  list_ids[i] = list_ids[i+1];
                  list_keys[i] = list_keys[i+1];
               end
               list_len--;
            end else begin
               r.status = ST_MISSING;
            end
         end
         default: begin
            pos = rank;
            if (rank < list_len) begin
               r.read_id = list_ids[rank];
               r.read_z = list_keys[rank];
            end else begin
               r.status = ST_EMPTY;
            end
         end
      endcase
      r.position = pos[3:0];
      r.entry_count = list_len[4:0];
      r.top_id = (list_len > 0) ? list_ids[0] : 8'h00;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Offers one word, with an optional idle gap first, and records the
   // predicted reply once the word has been taken.
   task automatic send_word(input mode_type mode, input logic [7:0] id,
                            input logic [15:0] z, input logic [3:0] rank);
      int gap;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_win_id <= id;
      req_z_value <= z;
      req_rank <= rank;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      replies_due.push_back(apply_window_op(mode, id, z, rank));
   endtask

   task automatic drain_list();
      while (list_len > 0) begin
         send_word(MODE_DETACH, list_ids[$urandom_range(0, list_len - 1)],
                   16'($urandom), 4'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      window_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            report_mismatch("reply word arrived with nothing outstanding");
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d, expected %0d",
                                         rsp_status, want.status));
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position got %0d, expected %0d",
                                         rsp_position, want.position));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count got %0d, expected %0d",
                                         rsp_entry_count, want.entry_count));
            if (rsp_top_id !== want.top_id)
               report_mismatch($sformatf("top_id got %0h, expected %0h",
                                         rsp_top_id, want.top_id));
            if (rsp_read_id !== want.read_id)
               report_mismatch($sformatf("read_id got %0h, expected %0h",
                                         rsp_read_id, want.read_id));
            if (rsp_read_z !== want.read_z)
               report_mismatch($sformatf("read_z got %0h, expected %0h",
                                         rsp_read_z, want.read_z));
         end
      end
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Empty-list reads, missing ids, equal keys, key extremes and duplicates.
   task automatic test_directed_cases();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_word(MODE_READ, 8'h00, 16'hFFFF, 4'd0);
      send_word(MODE_READ, 8'hFF, 16'h0000, 4'd15);
      send_word(MODE_DETACH, 8'h5A, 16'hFFFF, 4'd15);
      send_word(MODE_INSERT, 8'h00, 16'h0000, 4'd15);
      send_word(MODE_INSERT, 8'hFF, 16'hFFFF, 4'd0);
      send_word(MODE_INSERT, 8'h12, 16'hFFFF, 4'd7);
      send_word(MODE_INSERT, 8'h34, 16'h0000, 4'd8);
      send_word(MODE_PUSH, 8'hA5, 16'h0000, 4'd15);
      send_word(MODE_INSERT, 8'h12, 16'h8000, 4'd0);
      send_word(MODE_PUSH, 8'h00, 16'hFFFF, 4'd0);
      send_word(MODE_INSERT, 8'hC3, 16'h8000, 4'd3);
      for (int r = 0; r < 6; r++) send_word(MODE_READ, 8'hFF, 16'hFFFF, r[3:0]);
      send_word(MODE_READ, 8'h00, 16'h5555, 4'd15);
      send_word(MODE_DETACH, 8'h12, 16'hAAAA, 4'd5);
      send_word(MODE_DETACH, 8'hA5, 16'h0000, 4'd0);
      send_word(MODE_DETACH, 8'h34, 16'hFFFF, 4'd15);
      send_word(MODE_DETACH, 8'h34, 16'h0000, 4'd10);
      send_word(MODE_READ, 8'hFF, 16'hFFFF, 4'd0);
      send_word(MODE_PUSH, 8'h7E, 16'hFFFF, 4'd9);
   endtask

   // A full list refuses new entries but still reports duplicates.
   task automatic test_full_list();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      drain_list();
      for (int i = 0; i < LIST_DEPTH_DEF; i++) begin
         send_word(MODE_INSERT, {i[3:0], 4'(15 - i)},
                   (i % 4 == 0) ? 16'hFFFF : 16'($urandom), 4'($urandom));
      end
      send_word(MODE_INSERT, 8'h99, 16'hFFFF, 4'd0);
      send_word(MODE_PUSH, 8'h99, 16'h0000, 4'd0);
      send_word(MODE_INSERT, list_ids[7], 16'h1234, 4'd0);
      send_word(MODE_PUSH, list_ids[15], 16'h4321, 4'd0);
      send_word(MODE_READ, 8'h00, 16'h0000, 4'd15);
      send_word(MODE_DETACH, list_ids[15], 16'h0000, 4'd0);
      send_word(MODE_PUSH, 8'h99, 16'h0000, 4'd0);
      send_word(MODE_READ, 8'h00, 16'h0000, 4'd15);
      drain_list();
   endtask

   // Alternates between growing and shrinking the list so that both the
   // full and the empty ends are visited many times.
   task automatic random_traffic(input int items);
      logic [7:0]  id_pool [0:23];
      logic [15:0] z_marks [0:5];
      bit growing;
      int pick;
      mode_type mode;
      logic [7:0] id;
      logic [15:0] z;
      logic [3:0] rank;
      z_marks = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
      foreach (id_pool[k]) id_pool[k] = 8'($urandom);
      growing = 1'b1;
      for (int n = 0; n < items; n++) begin
         if (n % 48 == 47) growing = !growing;
         pick = $urandom_range(0, 99);
         if (growing)
            mode = (pick < 45) ? MODE_INSERT : (pick < 60) ? MODE_PUSH :
                   (pick < 75) ? MODE_DETACH : MODE_READ;
         else
            mode = (pick < 15) ? MODE_INSERT : (pick < 20) ? MODE_PUSH :
                   (pick < 70) ? MODE_DETACH : MODE_READ;
         if (mode == MODE_DETACH && list_len > 0 && $urandom_range(0, 99) < 80)
            id = list_ids[$urandom_range(0, list_len - 1)];
         else if ($urandom_range(0, 99) < 60)
            id = id_pool[$urandom_range(0, 23)];
         else
            id = 8'($urandom);
         z = ($urandom_range(0, 99) < 40) ? z_marks[$urandom_range(0, 5)]
                                          : 16'($urandom);
         if ($urandom_range(0, 99) < 75 && list_len > 0)
            rank = 4'($urandom_range(0, list_len - 1));
         else
            rank = 4'($urandom_range(0, 15));
         send_word(mode, id, z, rank);
      end
   endtask

   task automatic test_no_idling();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      random_traffic(150);
   endtask

   task automatic test_sender_idle();
      sender_idle_pct = 65;
      receiver_stall_pct = 0;
      random_traffic(150);
   endtask

   task automatic test_receiver_stall();
      sender_idle_pct = 0;
      receiver_stall_pct = 65;
      random_traffic(150);
   endtask

   task automatic test_both_idle();
      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      random_traffic(150);
   endtask

   // The receiver refuses replies for a long stretch while words keep
   // coming, so the block fills and has to stall its input.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 120;
      random_traffic(50);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_list();
      test_no_idling();
      test_sender_idle();
      test_backpressure();
      test_receiver_stall();
      test_both_idle();
      req_valid <= 1'b0;
      receiver_stall_pct = 0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
